FILE: hdl/lcgrr_pkg.sv
// Shared constants and types for the LCG random range generator.
`timescale 1ns / 1ps

package lcgrr_pkg;

  localparam logic [15:0] LCG_MUL = 16'd2053;
  localparam logic [15:0] LCG_ADD = 16'd13849;
  localparam logic [7:0]  MIN_WHEEL_DISTANCE = 8'd42;
  localparam logic [7:0]  WHEEL_SPAN = 8'd255;

  typedef enum logic [2:0] {
    OP_RAND8   = 3'd0,
    OP_SCALE8  = 3'd1,
    OP_RANGE8  = 3'd2,
    OP_RAND16  = 3'd3,
    OP_SCALE16 = 3'd4,
    OP_RANGE16 = 3'd5,
    OP_WHEEL   = 3'd6,
    OP_NONE    = 3'd7
  } op_t;

  // Operands for the shared multiply-add unit: p = a * b + c
  typedef struct packed {
    logic [15:0] a;
    logic [15:0] b;
    logic [15:0] c;
  } mul_req_t;

endpackage

FILE: hdl/lcgrr_mul.sv
// Shared 16x16 multiply-add unit with registered product.
`timescale 1ns / 1ps

module lcgrr_mul (
  input  logic              clk,
  input  lcgrr_pkg::mul_req_t req,
  output logic [31:0]       prod
);
  import lcgrr_pkg::*;

  // a*b + c tops out at 2^32 - 2^16, so 32 bits never overflow
  always_ff @(posedge clk) begin
    prod <= 32'(req.a) * 32'(req.b) + 32'(req.c);
  end

endmodule

FILE: hdl/lcg_random_range_generator.sv
// Top level: LCG random generator with scaled, ranged and wheel-index draws.
//
//   channel   dir   handshake          payload
//   s_*       in    s_tvalid/s_tready  tuser: operation; tdata: lower, upper, reference
//   m_*       out   m_tvalid/m_tready  tdata: value
//
// One beat in, one beat out. The multiply-add unit runs once for the LCG step
// and once more for scaled/ranged forms, which add a scale state after the
// draw state; a wheel index repeats the LCG and draw states per redraw.
// The unused code answers 0 at once. rst clears the state to zero; a stalled
// result sits in the output register and new beats wait until it has been taken.
`timescale 1ns / 1ps

module lcg_random_range_generator (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // [15:0] lower_bound, [31:16] upper_bound,
                                 // [39:32] reference_index
  input  logic [2:0]  s_tuser,   // [2:0] operation
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // [15:0] value
);
  import lcgrr_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LCG,
    ST_DRAW,
    ST_SCALE
  } state_t;

  state_t      state;
  op_t         op_q;
  logic [15:0] lo_q;
  logic [15:0] hi_q;
  logic [7:0]  ref_q;
  logic [15:0] lcg_state;
  logic [15:0] draw_cnt;

  mul_req_t    req;
  logic [31:0] prod;

  logic [15:0] s16;
  logic [7:0]  d8;
  logic [7:0]  x;
  logic [7:0]  y;
  logic [7:0]  wheel_gap;
  logic        far;
  logic        is8;
  logic [15:0] lim;
  logic [15:0] scaled;
  logic        s_beat;

  lcgrr_mul u_mul (
    .clk  (clk),
    .req  (req),
    .prod (prod)
  );

  assign s_tready = (state == ST_IDLE) && (!m_tvalid || m_tready);
  assign s_beat   = s_tvalid && s_tready;

  // fresh state is in prod[15:0] during ST_DRAW
  assign s16 = prod[15:0];
  assign d8  = s16[7:0] + s16[15:8];

  always_comb begin
    x         = (ref_q >= d8) ? (ref_q - d8) : (d8 - ref_q);
    y         = WHEEL_SPAN - x;
    wheel_gap = (x < y) ? x : y;
    far       = (wheel_gap >= MIN_WHEEL_DISTANCE);
  end

  assign is8 = (op_q == OP_SCALE8) || (op_q == OP_RANGE8);

  always_comb begin
    case (op_q)
      OP_SCALE8:  lim = {8'd0, hi_q[7:0]};
      OP_RANGE8:  lim = {8'd0, hi_q[7:0] - lo_q[7:0]};
      OP_SCALE16: lim = hi_q;
      OP_RANGE16: lim = hi_q - lo_q;
      default:    lim = 16'd0;
    endcase
  end

  always_comb begin
    if (state == ST_DRAW) begin
      req.a = is8 ? {8'd0, d8} : s16;
      req.b = lim;
      req.c = 16'd0;
    end else begin
      req.a = lcg_state;
      req.b = LCG_MUL;
      req.c = LCG_ADD;
    end
  end

  always_comb begin
    case (op_q)
      OP_SCALE8:  scaled = {8'd0, prod[15:8]};
      OP_RANGE8:  scaled = {8'd0, prod[15:8] + lo_q[7:0]};
      OP_SCALE16: scaled = prod[31:16];
      OP_RANGE16: scaled = prod[31:16] + lo_q;
      default:    scaled = 16'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      lcg_state <= 16'd0;
      m_tvalid  <= 1'b0;
      op_q      <= OP_NONE;
      draw_cnt  <= 16'd0;
    end else begin
      // a zero answer loaded in the same cycle keeps tvalid high
      if (m_tvalid && m_tready && !(s_beat && op_t'(s_tuser) == OP_NONE)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_beat) begin
            op_q     <= op_t'(s_tuser);
            lo_q     <= s_tdata[15:0];
            hi_q     <= s_tdata[31:16];
            ref_q    <= s_tdata[39:32];
            draw_cnt <= 16'd0;
            if (op_t'(s_tuser) == OP_NONE) begin
              m_tdata  <= 16'd0;
              m_tvalid <= 1'b1;
            end else begin
              state <= ST_LCG;
            end
          end
        end
        ST_LCG: begin
          state <= ST_DRAW;
        end
        ST_DRAW: begin
          lcg_state <= s16;
          unique case (op_q)
            OP_RAND8: begin
              m_tdata  <= {8'd0, d8};
              m_tvalid <= 1'b1;
              state    <= ST_IDLE;
            end
            OP_RAND16: begin
              m_tdata  <= s16;
              m_tvalid <= 1'b1;
              state    <= ST_IDLE;
            end
            OP_WHEEL: begin
              // give up after one full period and return the last draw
              if (far || (draw_cnt == 16'hFFFF)) begin
                m_tdata  <= {8'd0, d8};
                m_tvalid <= 1'b1;
                state    <= ST_IDLE;
              end else begin
                draw_cnt <= draw_cnt + 16'd1;
                state    <= ST_LCG;
              end
            end
            default: begin
              state <= ST_SCALE;
            end
          endcase
        end
        ST_SCALE: begin
          m_tdata  <= scaled;
          m_tvalid <= 1'b1;
          state    <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // a result is only produced into an empty output register
  a_slot_free: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCALE || state == ST_DRAW) |-> !m_tvalid)
    else $error("result would overwrite a pending beat");

  // the LCG state advances only out of the draw step
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    (state != ST_DRAW) |=> $stable(lcg_state))
    else $error("LCG state changed outside a draw");

  a_state_load: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DRAW) |=> (lcg_state == $past(prod[15:0])))
    else $error("LCG state not loaded from the multiply unit");

  // narrow forms never set the upper byte
  a_narrow: assert property (@(posedge clk) disable iff (rst)
    ($rose(m_tvalid) && (op_q == OP_RAND8 || op_q == OP_SCALE8 ||
      op_q == OP_RANGE8 || op_q == OP_WHEEL)) |-> (m_tdata[15:8] == 8'd0))
    else $error("upper byte set on an 8-bit result");

  a_seq: assert property (@(posedge clk) disable iff (rst)
    (s_beat && s_tuser != OP_NONE) |=> (state == ST_LCG && !s_tready))
    else $error("accepted beat did not start a draw");

endmodule

FILE: verif/lcgrr_value_checker.sv
// Checker for the LCG random range generator: predicts each value and compares beats.
`timescale 1ns / 1ps

module lcgrr_value_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [39:0] s_tdata,   // [15:0] lower_bound, [31:16] upper_bound,
                                 // [39:32] reference_index
  input  logic [2:0]  s_tuser,   // [2:0] operation
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [15:0] m_tdata,   // [15:0] value
  output int          fail_count,
  output int          pending
);
  import lcgrr_pkg::*;

  logic [15:0] lcg_state = '0;
  logic [15:0] expected_values[$];
  logic [15:0] oldest_value;

  initial begin
    fail_count = 0;
    pending = 0;
  end

  function automatic logic [15:0] advance_state();
    lcg_state = lcg_state * LCG_MUL + LCG_ADD;
    return lcg_state;
  endfunction

  // low byte of state + (state >> 8)
  function automatic logic [7:0] draw_byte();
    logic [15:0] s;
    s = advance_state();
    return s[7:0] + s[15:8];
  endfunction

  function automatic logic [7:0] scale_byte(input logic [7:0] lim);
    logic [15:0] prod;
    prod = draw_byte() * lim;
    return prod[15:8];
  endfunction

  function automatic logic [15:0] scale_word(input logic [15:0] lim);
    logic [31:0] prod;
    prod = advance_state() * lim;
    return prod[31:16];
  endfunction

  // Redraw until the circular distance to the reference reaches the minimum;
  // capped at one full period of the state.
  function automatic logic [7:0] wheel_pick(input logic [7:0] wheel_ref);
    logic [7:0] r;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] d;
    int n;
    r = '0;
    for (n = 0; n < 65536; n++) begin
      r = draw_byte();
      x = (wheel_ref >= r) ? wheel_ref - r : r - wheel_ref;
      y = WHEEL_SPAN - x;
      d = (x < y) ? x : y;
      if (d >= MIN_WHEEL_DISTANCE) break;
    end
    return r;
  endfunction

  function automatic logic [15:0] predict_value(input op_t op, input logic [15:0] lo,
                                                input logic [15:0] hi,
                                                input logic [7:0] wheel_ref);
    logic [7:0] diff8;
    logic [7:0] sum8;
    logic [15:0] v;
    v = '0;
    case (op)
      OP_RAND8:   v = {8'h00, draw_byte()};
      OP_SCALE8:  v = {8'h00, scale_byte(hi[7:0])};
      OP_RANGE8: begin
        diff8 = hi[7:0] - lo[7:0];
        sum8 = scale_byte(diff8) + lo[7:0];
        v = {8'h00, sum8};
      end
      OP_RAND16:  v = advance_state();
      OP_SCALE16: v = scale_word(hi);
      OP_RANGE16: v = scale_word(hi - lo) + lo;
      OP_WHEEL:   v = {8'h00, wheel_pick(wheel_ref)};
      default:    v = '0;
    endcase
    return v;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      lcg_state = '0;
      expected_values.delete();
      pending = 0;
    end else begin
      if (s_tvalid && s_tready)
        expected_values.push_back(predict_value(op_t'(s_tuser), s_tdata[15:0],
                                                s_tdata[31:16], s_tdata[39:32]));
      if (m_tvalid && m_tready) begin
        if (expected_values.size() == 0) begin
          $display("%0t: unexpected beat, value %h", $time, m_tdata);
          fail_count++;
        end else begin
          oldest_value = expected_values.pop_front();
          if (m_tdata !== oldest_value) begin
            $display("%0t: value mismatch, expected %h, actual %h",
                     $time, oldest_value, m_tdata);
            fail_count++;
          end
        end
      end
      pending = expected_values.size();
    end
  end

endmodule

FILE: verif/lcg_random_range_generator_tb.sv
// Testbench top for the LCG random range generator: stimulus, idling and verdict.
`timescale 1ns / 1ps

module lcg_random_range_generator_tb;
  import lcgrr_pkg::*;

  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int HOLD_OFF_CYCLES = 200;
  localparam int PHASE_ITEMS     = 420;
  localparam int DRAIN_CYCLES    = 20;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic [2:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;

  int fail_count;
  int pending;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_req_count = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int phase;
  int i;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  lcg_random_range_generator DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  lcgrr_value_checker value_check (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Result side: random stalls, plus a long hold-off when the sender asks for one.
  always @(negedge clk) begin
    if (hold_req_count != hold_seen) begin
      hold_seen <= hold_req_count;
      hold_left <= HOLD_OFF_CYCLES;
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Called just after a falling edge; returns just after a falling edge with
  // tvalid still high, so the next beat can follow back to back.
  task automatic send_item(input op_t op, input logic [15:0] lo, input logic [15:0] hi,
                           input logic [7:0] wheel_ref);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {wheel_ref, hi, lo};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  function automatic logic [15:0] pick_bound();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) return 16'h0000;
    if (pick == 1) return 16'hFFFF;
    if (pick == 2) return 16'h00FF;
    return 16'($urandom_range(0, 65535));
  endfunction

  task automatic send_random_item();
    op_t op;
    logic [15:0] lo;
    logic [15:0] hi;
    if ($urandom_range(0, 99) < 3) op = OP_NONE;
    else op = op_t'($urandom_range(0, 6));
    lo = pick_bound();
    hi = pick_bound();
    send_item(op, lo, hi, 8'($urandom_range(0, 255)));
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_item(OP_RAND8,   16'h0000, 16'h0000, 8'h00);
    send_item(OP_RAND8,   16'hFFFF, 16'hFFFF, 8'hFF);
    send_item(OP_SCALE8,  16'h0000, 16'h0000, 8'h00);
    send_item(OP_SCALE8,  16'h0000, 16'h00FF, 8'h00);
    send_item(OP_SCALE8,  16'hFFFF, 16'hFF00, 8'hFF);
    // upper below lower: 8-bit difference and sum wrap
    send_item(OP_RANGE8,  16'h00F0, 16'h0010, 8'h00);
    send_item(OP_RANGE8,  16'h0000, 16'h00FF, 8'h00);
    send_item(OP_RANGE8,  16'h0033, 16'h0033, 8'h00);
    send_item(OP_RANGE8,  16'hABFF, 16'h12FE, 8'h00);
    send_item(OP_RAND16,  16'h0000, 16'h0000, 8'h00);
    send_item(OP_SCALE16, 16'h0000, 16'h0000, 8'h00);
    send_item(OP_SCALE16, 16'h0000, 16'hFFFF, 8'h00);
    send_item(OP_RANGE16, 16'hFFFF, 16'h0000, 8'h00);
    send_item(OP_RANGE16, 16'h0000, 16'hFFFF, 8'h00);
    send_item(OP_RANGE16, 16'h1234, 16'h1234, 8'h00);
    send_item(OP_RANGE16, 16'h8000, 16'h7FFF, 8'h00);
    send_item(OP_WHEEL,   16'h0000, 16'h0000, 8'h00);
    send_item(OP_WHEEL,   16'h0000, 16'h0000, 8'hFF);
    send_item(OP_WHEEL,   16'h0000, 16'h0000, 8'h7F);
    send_item(OP_WHEEL,   16'hFFFF, 16'hFFFF, 8'h80);
    // unused code: state untouched, answers zero
    send_item(OP_NONE,    16'hFFFF, 16'hFFFF, 8'hFF);
    send_item(OP_RAND16,  16'h0000, 16'h0000, 8'h00);
    wait_idle();

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 67;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 67;
        end
        default: begin
          send_idle_pct = 34;
          recv_stall_pct = 34;
        end
      endcase
      for (i = 0; i < PHASE_ITEMS; i++) begin
        // long output hold-off while beats keep coming, so the input backs up
        if (phase == 0 && i == 150) hold_req_count++;
        if (phase == 2 && i == 200) wait_idle();
        send_random_item();
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/lcgrr_pkg.sv
hdl/lcgrr_mul.sv
hdl/lcg_random_range_generator.sv
verif/lcgrr_value_checker.sv
verif/lcg_random_range_generator_tb.sv
